// ===== sv/imfd_pkg.sv =====
package imfd_pkg;

    localparam int SIG_COUNT  = 8;
    localparam int SIG_SLOTS  = 16;
    localparam int POS_W      = 8;
    localparam int CODE_W     = 3;

    localparam logic [POS_W-1:0] DICOM_PREFIX = 8'd128;
    localparam logic [POS_W-1:0] DICOM_END    = 8'd132;

    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 3'd0;
    localparam logic [CODE_W-1:0] CODE_JPEG    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_J2K     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_PNG     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_TIFF    = 3'd4;
    localparam logic [CODE_W-1:0] CODE_DICOM   = 3'd5;

    // Signature order: jpeg, j2k codestream, jp2 box, png,
    // tiff BE, tiff LE, bigtiff BE, bigtiff LE.
    localparam logic [3:0] SIG_LEN [SIG_COUNT] = '{
        4'd3, 4'd4, 4'd12, 4'd8, 4'd4, 4'd4, 4'd8, 4'd8
    };

    localparam logic [7:0] SIG_BYTES [SIG_COUNT][SIG_SLOTS] = '{
        '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'h4F, 8'hFF, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h0C, 8'h6A, 8'h50, 8'h20, 8'h20,
          8'h0D, 8'h0A, 8'h87, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4D, 8'h00, 8'h2B, 8'h00, 8'h08, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2B, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // "DICM"
    localparam logic [7:0] DICM_TAG [4] = '{8'h44, 8'h49, 8'h43, 8'h4D};

endpackage

// ===== sv/imfd_in_if.sv =====
interface imfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

// ===== sv/imfd_out_if.sv =====
interface imfd_out_if;
    logic                          valid;
    logic                          ready;
    logic [imfd_pkg::CODE_W-1:0]   format_code;

    modport source (output valid, output format_code, input ready);
    modport sink   (input valid, input format_code, output ready);
endinterface

// ===== sv/image_format_magic_detector.sv =====
// Image format detector: feed the leading bytes of a file, one request per
// byte from offset zero, with last_byte set on the final one. On that byte the
// block returns one format code (0 unknown, 1 JPEG, 2 JPEG 2000, 3 PNG,
// 4 TIFF/BigTIFF, 5 DICOM), picked in that priority order; other bytes give no
// result. A signature counts only if the stream is at least as long as it;
// DICOM needs 128 zero bytes followed by "DICM". Bytes past offset 131 are
// ignored. After the marked byte the block starts over on a new stream. One
// byte is taken every cycle while the result side keeps up; a result held by
// the sink stalls the input until it drains. A request passes through the
// input register, then the match logic, and then the result register.
module image_format_magic_detector (
    input  logic            i_clk,
    input  logic            i_rst_n,
    imfd_in_if.sink         i_req,
    imfd_out_if.source      o_res
);

    // Input register.
    logic                                 r_in_valid;
    logic [7:0]                           r_in_byte;
    logic                                 r_in_last;

    // Stream tracking state.
    logic [imfd_pkg::POS_W-1:0]           r_pos;
    logic [imfd_pkg::SIG_COUNT-1:0]       r_alive;
    logic                                 r_zero;
    logic                                 r_dicm;

    // Result register.
    logic                                 r_out_valid;
    logic [imfd_pkg::CODE_W-1:0]          r_code;

    logic [imfd_pkg::POS_W-1:0]           n_pos;
    logic [imfd_pkg::SIG_COUNT-1:0]       n_alive;
    logic                                 n_zero;
    logic                                 n_dicm;
    logic [imfd_pkg::CODE_W-1:0]          n_code;
    logic [imfd_pkg::SIG_COUNT-1:0]       w_counts;
    logic                                 w_adv;

    // Advance the match stage whenever the result register is free or drains.
    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || w_adv;

    assign o_res.valid       = r_out_valid;
    assign o_res.format_code = r_code;

    // Match logic: update flags with the held byte, then pick the code from
    // the updated flags and length.
    always_comb begin
        n_pos   = r_pos;
        n_alive = r_alive;
        n_zero  = r_zero;
        n_dicm  = r_dicm;
        if (r_pos < imfd_pkg::DICOM_END) begin
            for (int k = 0; k < imfd_pkg::SIG_COUNT; k++) begin
                if ((r_pos < {4'd0, imfd_pkg::SIG_LEN[k]})
                        && (r_in_byte != imfd_pkg::SIG_BYTES[k][r_pos[3:0]])) begin
                    n_alive[k] = 1'b0;
                end
            end
            if (r_pos < imfd_pkg::DICOM_PREFIX) begin
                if (r_in_byte != 8'd0) begin
                    n_zero = 1'b0;
                end
            end else if (r_in_byte != imfd_pkg::DICM_TAG[r_pos[1:0]]) begin
                n_dicm = 1'b0;
            end
            n_pos = r_pos + 8'd1;
        end

        for (int k = 0; k < imfd_pkg::SIG_COUNT; k++) begin
            w_counts[k] = n_alive[k] && (n_pos >= {4'd0, imfd_pkg::SIG_LEN[k]});
        end

        if (w_counts[0]) begin
            n_code = imfd_pkg::CODE_JPEG;
        end else if (w_counts[1] || w_counts[2]) begin
            n_code = imfd_pkg::CODE_J2K;
        end else if (w_counts[3]) begin
            n_code = imfd_pkg::CODE_PNG;
        end else if (|w_counts[7:4]) begin
            n_code = imfd_pkg::CODE_TIFF;
        end else if ((n_pos >= imfd_pkg::DICOM_END) && n_zero && n_dicm) begin
            n_code = imfd_pkg::CODE_DICOM;
        end else begin
            n_code = imfd_pkg::CODE_UNKNOWN;
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_alive     <= '1;
            r_zero      <= 1'b1;
            r_dicm      <= 1'b1;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid && r_in_last;
                if (r_in_valid) begin
                    if (r_in_last) begin
                        // Stream done: start over for the next one.
                        r_pos   <= '0;
                        r_alive <= '1;
                        r_zero  <= 1'b1;
                        r_dicm  <= 1'b1;
                    end else begin
                        r_pos   <= n_pos;
                        r_alive <= n_alive;
                        r_zero  <= n_zero;
                        r_dicm  <= n_dicm;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_byte <= i_req.byte_value;
            r_in_last <= i_req.last_byte;
        end
        if (w_adv && r_in_valid && r_in_last) begin
            r_code <= n_code;
        end
    end

endmodule
